// ===== rtl/sorted_insert_priority_queue_top_defines.svh =====
// Assertion macros for the sorted-insert priority queue.
// Included by the top level; depends on nothing else.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Checked only outside reset
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted-insert priority queue.
// Used by spq_cell and the top level; no dependencies.
package spq_pkg;

   localparam int VALUE_W = 32;
   localparam int OCC_W   = 5;

   // Item operation codes
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell for one item
   typedef struct packed {
      logic                      load;
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   // Handed from a cell to its right-hand neighbor
   typedef struct packed {
      logic                      gt;
      logic signed [VALUE_W-1:0] value;
   } link_type;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds a value, compares it to the item.
// Depends on spq_pkg.
module spq_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                              clock,
   input  spq_pkg::cmd_type                  cmd,
   input  logic [CNT_W-1:0]                  count,
   input  spq_pkg::link_type                 left_link,
   input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
   output spq_pkg::link_type                 link_out
);
   import spq_pkg::*;

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      occupied;
   logic                      at_end;
   logic                      gt;

   // Slot status relative to the fill level
   assign occupied = CNT_W'(IDX) < count;
   assign at_end   = CNT_W'(IDX) == count;
   assign gt       = occupied && (value_ff > cmd.value);

   assign link_out.gt    = gt;
   assign link_out.value = value_ff;

   // Insert shifts larger values right; remove shifts everything left
   always_comb begin
      value_in = value_ff;
      if (cmd.load) begin
         unique case (cmd.op)
            OP_REMOVE: value_in = right_value;
            OP_INSERT: begin
               priority if (left_link.gt) begin
                  value_in = left_link.value;
               end else if (gt || at_end) begin
                  value_in = cmd.value;
               end
            end
            default: value_in = value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/sorted_insert_priority_queue_top.sv =====
// Sorted-insert min priority queue: a chain of DEPTH compare-and-shift cells.
// The result is strobed in the cycle after the item is taken (start high).
// Throughput: one item per cycle; busy stays low, the chain settles each cycle.
// Reset (synchronous) empties the queue; stored values are not cleared.
// Depends on spq_pkg, spq_cell and the defines header.
`include "sorted_insert_priority_queue_top_defines.svh"
module sorted_insert_priority_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [spq_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic signed [spq_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic [1:0]                          rsp_status,
   output logic [spq_pkg::OCC_W-1:0]           rsp_occupancy
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      accept;
   logic                      full, empty;
   op_type                    op;
   cmd_type                   cmd;
   status_type                status;
   link_type                  links [DEPTH];
   logic signed [VALUE_W-1:0] right_vals [DEPTH];

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] removed_ff, removed_in;
   status_type                status_ff;
   logic [OCC_W-1:0]          occ_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = op_type'(req_op);
   assign full   = count_ff == CNT_W'(DEPTH);
   assign empty  = count_ff == '0;

   // Decode the item into a chain command and a status
   always_comb begin
      cmd.op    = op;
      cmd.value = req_value;
      cmd.load  = 1'b0;
      status    = ST_OK;
      count_in  = count_ff;
      if (accept) begin
         unique case (op)
            OP_INSERT: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  cmd.load = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  cmd.load = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: status = ST_OK;
         endcase
      end
   end

   assign removed_in = (op == OP_REMOVE && cmd.load) ? links[0].value : '0;

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type left_link;
      if (i == 0) begin : g_head
         assign left_link = '0;
      end else begin : g_body
         assign left_link = links[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_vals[i] = links[i].value;
      end else begin : g_mid
         assign right_vals[i] = links[i+1].value;
      end
      spq_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_link   (left_link),
         .right_value (right_vals[i]),
         .link_out    (links[i])
      );
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      status_ff  <= status;
      occ_ff     <= OCC_W'(count_in);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_occupancy     = occ_ff;

   // Checks
   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH),
               "count above depth")
   `SPQ_ASSERT(a_rsp_follows, clock, reset, accept |=> rsp_valid, "item without result")
   `SPQ_ASSERT(a_empty_status, clock, reset,
               (accept && op == OP_REMOVE && empty) |=>
               (rsp_status == ST_EMPTY && rsp_removed_value == '0),
               "empty remove misreported")
   `SPQ_ASSERT(a_insert_grows, clock, reset,
               (cmd.load && op == OP_INSERT) |=> (count_ff == $past(count_ff) + 1'b1),
               "insert did not grow queue")
   `SPQ_ASSERT(a_head_sorted, clock, reset,
               (count_ff >= CNT_W'(2)) |-> (links[0].value <= links[1].value),
               "head out of order")

endmodule
